// ----- design/assert_macros.svh -----
// Assertion macros shared by the battery monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/bvm_pkg.sv -----
// Types and constants of the battery low-voltage monitor.
package bvm_pkg;

    localparam int ADC_W     = 10;
    localparam int ELAPSED_W = 20;
    localparam int AVG_W     = 11;
    localparam int THR_W     = 10;
    localparam int DELAY_W   = 24;
    localparam int TIMER_W   = 25;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;

    localparam int MV_SCALE     = 1000;
    localparam int ADC_FULL     = 1024;
    localparam int ADC_MAX      = 1023;
    localparam int SHIFT_W      = 10;

    localparam logic [AVG_W-1:0]   AVERAGE_RESET   = 11'd1000;
    localparam int                 SHUTDOWN_RESET  = 650;
    localparam int                 WARNING_RESET   = 680;
    localparam logic [DELAY_W-1:0] DELAY_RESET     = 24'd5000000;

    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_DLY = 2'd2;

    typedef struct packed {
        logic [ADC_W-1:0]     adc_sample;
        logic [ELAPSED_W-1:0] elapsed_us;
        logic                 dismiss;
    } in_t;

    typedef struct packed {
        logic [AVG_W-1:0] average_mv;
        logic             warning_active;
        logic             shutdown_active;
        logic             power_off;
        logic             modal_raised;
    } out_t;

endpackage

// ----- design/battery_low_voltage_monitor.sv -----
// Battery low-voltage monitor: averaging, threshold compare and shutdown timer.
//
// One request on the input channel is one tick: a converter sample, the
// microseconds since the previous tick and the dismiss button. Every request
// yields exactly one result on the output channel, in order.
// The sample sum is kept pre-scaled by 1000; after SAMPLES_PER_AVERAGE + 1
// samples it is divided by SAMPLES_PER_AVERAGE * 1024 with a reciprocal
// multiply and compared against the scaled thresholds in the same pass.
// An accepted request is held in the input register; its result passes in a
// single pass through the reciprocal multiplier into the result register.
// While the receiver takes results, a new request is accepted every cycle.
// When the receiver stalls, the result register holds and in_ready drops once
// the input register holds a request.
// Configuration writes (index 0 shutdown threshold, 1 warning threshold,
// 2 shutdown delay) are always accepted and must happen while the block is
// idle; other indexes are ignored.
// Reset clears sums, flags and the timer, sets the average to 1000 and loads
// the default thresholds and delay. Shutdown is left only through reset.
`include "assert_macros.svh"

module battery_low_voltage_monitor #(
    parameter int SAMPLES_PER_AVERAGE = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bvm_pkg::in_t                        in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bvm_pkg::out_t                       out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bvm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bvm_pkg::CFG_W-1:0]           cfg_data
);

    localparam int N = SAMPLES_PER_AVERAGE;
    localparam logic [63:0] ACC_MAX =
        64'(N + 1) * 64'(bvm_pkg::ADC_MAX) * 64'(bvm_pkg::MV_SCALE);
    localparam logic [63:0] ROUND_BIAS = 64'(N) * 64'(bvm_pkg::ADC_FULL / 2);
    localparam int ACC_W  = $clog2(ACC_MAX + 64'd1);
    localparam int RND_W  = $clog2(ACC_MAX + ROUND_BIAS + 64'd1);
    localparam int XW     = RND_W - bvm_pkg::SHIFT_W;
    localparam int SCL_W  = $clog2(64'(bvm_pkg::ADC_MAX) * 64'(N) + 64'd1);
    localparam int CMP_W  = (XW > SCL_W) ? XW : SCL_W;
    localparam int RSH    = XW + $clog2(N);
    localparam logic [63:0] RECIP = ((64'd1 << RSH) + 64'(N) - 64'd1) / 64'(N);
    localparam int MUL_W  = XW + RSH + 1;
    localparam int CNT_W  = $clog2(N + 2);
    localparam int SPW    = bvm_pkg::ADC_W + bvm_pkg::SHIFT_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(N + 1);
    localparam logic [SCL_W-1:0] SHUTDOWN_SCL_RESET = SCL_W'(bvm_pkg::SHUTDOWN_RESET * N);
    localparam logic [SCL_W-1:0] WARNING_SCL_RESET  = SCL_W'(bvm_pkg::WARNING_RESET * N);

    bvm_pkg::in_t  in_reg;
    bvm_pkg::out_t out_reg, out_next;
    logic          s1_valid_reg, s1_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic          advance;

    logic [SCL_W-1:0]            sd_scl_reg, warn_scl_reg;
    logic [bvm_pkg::DELAY_W-1:0] delay_reg;

    logic [ACC_W-1:0]            acc_reg, acc_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [bvm_pkg::AVG_W-1:0]   average_reg, average_next;
    logic                        warning_reg, warning_next;
    logic                        shown_reg, shown_next;
    logic                        shutdown_reg, shutdown_next;
    logic [bvm_pkg::TIMER_W-1:0] timer_reg, timer_next;

    logic [SPW-1:0]              sample_scaled;
    logic [RND_W-1:0]            rounded;
    logic [MUL_W-1:0]            product;
    logic [CMP_W-1:0]            acc_floor;
    logic                        do_average;
    logic                        below_sd, below_warn;
    logic [bvm_pkg::TIMER_W:0]   timer_sum;
    logic [bvm_pkg::TIMER_W-1:0] timer_sat;
    logic                        power;
    logic                        modal;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // Thresholds are stored pre-multiplied by the sample count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sd_scl_reg   <= SHUTDOWN_SCL_RESET;
            warn_scl_reg <= WARNING_SCL_RESET;
            delay_reg    <= bvm_pkg::DELAY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bvm_pkg::CFG_SHUTDOWN_THR:
                begin
                    sd_scl_reg <= SCL_W'(cfg_data[bvm_pkg::THR_W-1:0]) * SCL_W'(N);
                end
                bvm_pkg::CFG_WARNING_THR:
                begin
                    warn_scl_reg <= SCL_W'(cfg_data[bvm_pkg::THR_W-1:0]) * SCL_W'(N);
                end
                bvm_pkg::CFG_SHUTDOWN_DLY:
                begin
                    delay_reg <= cfg_data[bvm_pkg::DELAY_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        sample_scaled = SPW'(in_reg.adc_sample) * SPW'(bvm_pkg::MV_SCALE);
        rounded       = RND_W'(acc_reg) + RND_W'(ROUND_BIAS);
        product       = MUL_W'(rounded[RND_W-1:bvm_pkg::SHIFT_W]) * MUL_W'(RECIP);
        acc_floor     = CMP_W'(acc_reg[ACC_W-1:bvm_pkg::SHIFT_W]);
        below_sd      = acc_floor < CMP_W'(sd_scl_reg);
        below_warn    = acc_floor < CMP_W'(warn_scl_reg);
        do_average    = count_reg == CNT_FULL;

        timer_sum = {1'b0, timer_reg} + (bvm_pkg::TIMER_W + 1)'(in_reg.elapsed_us);
        timer_sat = timer_sum[bvm_pkg::TIMER_W] ? {bvm_pkg::TIMER_W{1'b1}}
                                                : timer_sum[bvm_pkg::TIMER_W-1:0];

        timer_next    = timer_reg;
        power         = 1'b0;
        if (shutdown_reg)
        begin
            timer_next = timer_sat;
            power      = timer_sat >= bvm_pkg::TIMER_W'(delay_reg);
        end

        warning_next  = warning_reg && !in_reg.dismiss;
        shown_next    = shown_reg;
        shutdown_next = shutdown_reg;
        average_next  = average_reg;
        modal         = 1'b0;
        acc_next      = acc_reg + ACC_W'(sample_scaled);
        count_next    = count_reg + CNT_W'(1);

        if (do_average)
        begin
            average_next = product[RSH+bvm_pkg::AVG_W-1:RSH];
            acc_next     = ACC_W'(sample_scaled);
            count_next   = CNT_W'(1);
            if (below_sd && !shutdown_reg)
            begin
                shutdown_next = 1'b1;
                timer_next    = '0;
                modal         = 1'b1;
            end
            else if (below_warn && !shown_reg)
            begin
                warning_next = 1'b1;
                shown_next   = 1'b1;
                modal        = 1'b1;
            end
        end

        out_next.average_mv      = average_next;
        out_next.warning_active  = warning_next;
        out_next.shutdown_active = shutdown_next;
        out_next.power_off       = power;
        out_next.modal_raised    = modal;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            count_reg    <= '0;
            average_reg  <= bvm_pkg::AVERAGE_RESET;
            warning_reg  <= 1'b0;
            shown_reg    <= 1'b0;
            shutdown_reg <= 1'b0;
            timer_reg    <= '0;
        end
        else if (advance)
        begin
            acc_reg      <= acc_next;
            count_reg    <= count_next;
            average_reg  <= average_next;
            warning_reg  <= warning_next;
            shown_reg    <= shown_next;
            shutdown_reg <= shutdown_next;
            timer_reg    <= timer_next;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_FULL)
    `ASSERT_NEXT(a_shutdown_sticky, clk, rst_n, shutdown_reg, shutdown_reg)
    `ASSERT_IMPLIES(a_power_in_shutdown, clk, rst_n, out_valid_reg && out_reg.power_off, out_reg.shutdown_active)
    `ASSERT_IMPLIES(a_modal_raises, clk, rst_n, out_valid_reg && out_reg.modal_raised, out_reg.shutdown_active || out_reg.warning_active)
    `ASSERT_IMPLIES(a_warning_once, clk, rst_n, warning_reg, shown_reg)

endmodule
